@@ rtl/core/relative_strength_index_top_macros.svh @@
// assertion macros shared by the rsi checker
// no dependencies; expects clk and rst_n in the including scope
`ifndef RELATIVE_STRENGTH_INDEX_TOP_MACROS_SVH
`define RELATIVE_STRENGTH_INDEX_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define RSI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define RSI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rsi_pkg.sv @@
// shared constants for the relative strength index block
// no dependencies
`default_nettype none

package rsi_pkg;

  localparam int ACC_BITS           = 64;  // modular width of sums and averages
  localparam int PERIOD_BITS        = 10;
  localparam int COUNT_BITS         = 11;
  localparam int RSI_BITS           = 23;
  localparam int HUNDRED_BITS       = 7;   // 100 fits in 7 bits
  localparam int PRICE_BITS_DEF     = 32;
  localparam int FRACTION_BITS_DEF  = 16;

  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 10'd14;
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = 11'd2047;

endpackage

`default_nettype wire

@@ rtl/core/rsi_serial_mul.sv @@
// bit-serial multiply of an average by (period - 1), plus an addend, mod 2^64
// depends on rsi_pkg
`default_nettype none

module rsi_serial_mul (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [rsi_pkg::ACC_BITS-1:0]    multiplicand,
  input  wire logic [rsi_pkg::PERIOD_BITS-1:0] multiplier,
  input  wire logic [rsi_pkg::ACC_BITS-1:0]    addend,
  output logic                              done,
  output logic [rsi_pkg::ACC_BITS-1:0]         result
);
  import rsi_pkg::*;

  localparam int MCNT_BITS = $clog2(PERIOD_BITS + 1);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [MCNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [ACC_BITS-1:0]    mcand_r, mcand_nxt;
  logic [PERIOD_BITS-1:0] mplier_r, mplier_nxt;
  logic [ACC_BITS-1:0]    prod_r, prod_nxt;

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    prod_nxt   = prod_r;
    if (start) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = MCNT_BITS'(PERIOD_BITS);
      mcand_nxt  = multiplicand;
      mplier_nxt = multiplier;
      prod_nxt   = addend;
    end else if (busy_r) begin
      // one multiplier bit per cycle, lsb first
      if (mplier_r[0]) begin
        prod_nxt = prod_r + mcand_r;
      end
      mcand_nxt  = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r - MCNT_BITS'(1);
      if (cnt_r == MCNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    prod_r   <= prod_nxt;
  end

  assign done   = done_r;
  assign result = prod_r;

endmodule

`default_nettype wire

@@ rtl/core/rsi_serial_div.sv @@
// restoring divider of a 64-bit value by the 10-bit period, one quotient bit a cycle
// depends on rsi_pkg
`default_nettype none

module rsi_serial_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [rsi_pkg::ACC_BITS-1:0]    dividend,
  input  wire logic [rsi_pkg::PERIOD_BITS-1:0] divisor,
  output logic                              done,
  output logic [rsi_pkg::ACC_BITS-1:0]         quotient
);
  import rsi_pkg::*;

  localparam int DCNT_BITS = $clog2(ACC_BITS + 1);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [DCNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic [ACC_BITS-1:0]    quo_r, quo_nxt;   // dividend bits shift out, quotient bits in
  logic [PERIOD_BITS-1:0] rem_r, rem_nxt;
  logic [PERIOD_BITS-1:0] div_r, div_nxt;
  logic [PERIOD_BITS:0]   trial;
  logic                   ge;

  assign trial = {rem_r, quo_r[ACC_BITS-1]};
  assign ge    = trial >= {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_BITS'(ACC_BITS);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits the period width
      rem_nxt = ge ? PERIOD_BITS'(trial - {1'b0, div_r}) : PERIOD_BITS'(trial);
      quo_nxt = {quo_r[ACC_BITS-2:0], ge};
      cnt_nxt = cnt_r - DCNT_BITS'(1);
      if (cnt_r == DCNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

@@ rtl/core/rsi_ratio_div.sv @@
// serial divider for floor((100 << FRACTION_BITS) * gain / (gain + loss))
// depends on rsi_pkg; keeps the low result bits of the quotient
`default_nettype none

module rsi_ratio_div #(
  parameter int FRACTION_BITS = rsi_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [rsi_pkg::ACC_BITS-1:0] gain,
  input  wire logic [rsi_pkg::ACC_BITS-1:0] total,
  output logic                           done,
  output logic [rsi_pkg::RSI_BITS-1:0]      quotient
);
  import rsi_pkg::*;

  localparam int NUM_BITS  = ACC_BITS + HUNDRED_BITS;
  localparam int STEPS     = NUM_BITS + FRACTION_BITS;
  localparam int RCNT_BITS = $clog2(STEPS + 1);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [RCNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [NUM_BITS-1:0]  num_r, num_nxt;  // gain * 100; fraction zeros shift in behind it
  logic [ACC_BITS-1:0]  rem_r, rem_nxt;
  logic [ACC_BITS-1:0]  den_r, den_nxt;
  logic [RSI_BITS-1:0]  quo_r, quo_nxt;
  logic [ACC_BITS:0]    trial;
  logic                 ge;

  assign trial = {rem_r, num_r[NUM_BITS-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = RCNT_BITS'(STEPS);
      // 100 = 64 + 32 + 4
      num_nxt  = (NUM_BITS'(gain) << 6) + (NUM_BITS'(gain) << 5) + (NUM_BITS'(gain) << 2);
      rem_nxt  = '0;
      den_nxt  = total;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? ACC_BITS'(trial - {1'b0, den_r}) : ACC_BITS'(trial);
      num_nxt = num_r << 1;
      quo_nxt = {quo_r[RSI_BITS-2:0], ge};
      cnt_nxt = cnt_r - RCNT_BITS'(1);
      if (cnt_r == RCNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

@@ rtl/core/relative_strength_index_top.sv @@
// channel   dir   handshake              payload
// in        in    in_valid / in_ready    in_price, in_last
// out       out   out_valid / out_ready  out_rsi_value, out_short_series
// cfg       in    cfg_we                 cfg_wdata (period)
//
// a price in the summing phase is added to the sums directly; the price that closes the
// initial sums runs the 64-step serial divide by period; a smoothing price runs the
// 10-step serial multiply, then the 64-step divide
// a last price then runs the serial ratio divider when the series is full and has losses
// synchronous reset, no clearing pass; a stalled result waits in the output
// register while later prices are taken, until the next result needs the register
// depends on rsi_pkg, rsi_serial_mul, rsi_serial_div, rsi_ratio_div
`default_nettype none

module relative_strength_index_top #(
  parameter int PRICE_BITS    = rsi_pkg::PRICE_BITS_DEF,
  parameter int FRACTION_BITS = rsi_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [rsi_pkg::PERIOD_BITS-1:0] cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [PRICE_BITS-1:0]        in_price,
  input  wire logic                         in_last,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [rsi_pkg::RSI_BITS-1:0]         out_rsi_value,
  output logic                              out_short_series
);
  import rsi_pkg::*;

  localparam logic [RSI_BITS-1:0] FIFTY_FX   = RSI_BITS'(ACC_BITS'(50) << FRACTION_BITS);
  localparam logic [RSI_BITS-1:0] HUNDRED_FX = RSI_BITS'(ACC_BITS'(100) << FRACTION_BITS);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_DIV   = 6'b000100,
    S_FIN   = 6'b001000,
    S_RATIO = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [PERIOD_BITS-1:0] period_r, period_nxt;
  logic [PRICE_BITS-1:0]  prev_r, prev_nxt;
  logic [COUNT_BITS-1:0]  count_r, count_nxt;
  logic [ACC_BITS-1:0]    gain_r, gain_nxt;
  logic [ACC_BITS-1:0]    loss_r, loss_nxt;
  logic                   last_r, last_nxt;
  logic [RSI_BITS-1:0]    res_r, res_nxt;
  logic                   res_short_r, res_short_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [RSI_BITS-1:0]    out_rsi_r, out_rsi_nxt;
  logic                   out_short_r, out_short_nxt;

  logic                   accept;
  logic [PERIOD_BITS-1:0] p_eff;
  logic [COUNT_BITS-1:0]  p_cnt;
  logic                   up;
  logic [PRICE_BITS-1:0]  chg;
  logic [ACC_BITS-1:0]    gain_chg, loss_chg;
  logic [ACC_BITS-1:0]    gain_sum, loss_sum;
  logic                   has_prev, in_sum, at_p;

  logic                   mul_start, mul_done_g, mul_done_l;
  logic [ACC_BITS-1:0]    mul_res_g, mul_res_l;
  logic                   div_start, div_done_g, div_done_l;
  logic [ACC_BITS-1:0]    div_in_g, div_in_l, div_q_g, div_q_l;
  logic                   ratio_start, ratio_done;
  logic [RSI_BITS-1:0]    ratio_q;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // a zero period behaves as one
  assign p_eff = (period_r == '0) ? PERIOD_BITS'(1) : period_r;
  assign p_cnt = COUNT_BITS'(p_eff);

  assign up       = in_price > prev_r;
  assign chg      = up ? in_price - prev_r : prev_r - in_price;
  assign gain_chg = up ? ACC_BITS'(chg) : '0;
  assign loss_chg = up ? '0 : ACC_BITS'(chg);
  assign gain_sum = gain_r + gain_chg;
  assign loss_sum = loss_r + loss_chg;

  assign has_prev = (count_r != '0);
  assign in_sum   = (count_r <= p_cnt);
  assign at_p     = (count_r == p_cnt);

  assign mul_start = accept && has_prev && !in_sum;
  assign div_start = (accept && has_prev && at_p) ||
                     ((state_r == S_MUL) && mul_done_g && mul_done_l);
  assign div_in_g  = (state_r == S_MUL) ? mul_res_g : (gain_sum << FRACTION_BITS);
  assign div_in_l  = (state_r == S_MUL) ? mul_res_l : (loss_sum << FRACTION_BITS);
  assign ratio_start = (state_r == S_FIN) && (count_r > p_cnt) && (loss_r != '0);

  rsi_serial_mul u_mul_gain (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (mul_start),
    .multiplicand (gain_r),
    .multiplier   (p_eff - PERIOD_BITS'(1)),
    .addend       (gain_chg << FRACTION_BITS),
    .done         (mul_done_g),
    .result       (mul_res_g)
  );

  rsi_serial_mul u_mul_loss (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (mul_start),
    .multiplicand (loss_r),
    .multiplier   (p_eff - PERIOD_BITS'(1)),
    .addend       (loss_chg << FRACTION_BITS),
    .done         (mul_done_l),
    .result       (mul_res_l)
  );

  rsi_serial_div u_div_gain (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_in_g),
    .divisor  (p_eff),
    .done     (div_done_g),
    .quotient (div_q_g)
  );

  rsi_serial_div u_div_loss (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_in_l),
    .divisor  (p_eff),
    .done     (div_done_l),
    .quotient (div_q_l)
  );

  rsi_ratio_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ratio (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ratio_start),
    .gain     (gain_r),
    .total    (gain_r + loss_r),
    .done     (ratio_done),
    .quotient (ratio_q)
  );

  always_comb begin
    state_nxt     = state_r;
    period_nxt    = period_r;
    prev_nxt      = prev_r;
    count_nxt     = count_r;
    gain_nxt      = gain_r;
    loss_nxt      = loss_r;
    last_nxt      = last_r;
    res_nxt       = res_r;
    res_short_nxt = res_short_r;
    out_valid_nxt = out_valid_r;
    out_rsi_nxt   = out_rsi_r;
    out_short_nxt = out_short_r;

    if (cfg_we) begin
      period_nxt = cfg_wdata;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          prev_nxt  = in_price;
          count_nxt = (count_r == COUNT_MAX) ? count_r : count_r + COUNT_BITS'(1);
          last_nxt  = in_last;
          if (has_prev && in_sum) begin
            gain_nxt = gain_sum;
            loss_nxt = loss_sum;
          end
          if (has_prev && !in_sum) begin
            state_nxt = S_MUL;
          end else if (has_prev && at_p) begin
            state_nxt = S_DIV;
          end else if (in_last) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_MUL: begin
        if (mul_done_g && mul_done_l) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done_g && div_done_l) begin
          gain_nxt  = div_q_g;
          loss_nxt  = div_q_l;
          state_nxt = last_r ? S_FIN : S_IDLE;
        end
      end
      S_FIN: begin
        res_short_nxt = 1'b0;
        if (count_r <= p_cnt) begin
          res_nxt       = FIFTY_FX;
          res_short_nxt = 1'b1;
          state_nxt     = S_EMIT;
        end else if (loss_r == '0) begin
          res_nxt   = HUNDRED_FX;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_RATIO;
        end
      end
      S_RATIO: begin
        if (ratio_done) begin
          res_nxt   = ratio_q;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // wait for the output register, then start a fresh series
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rsi_nxt   = res_r;
          out_short_nxt = res_short_r;
          prev_nxt      = '0;
          count_nxt     = '0;
          gain_nxt      = '0;
          loss_nxt      = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      period_r    <= PERIOD_RESET;
      prev_r      <= '0;
      count_r     <= '0;
      gain_r      <= '0;
      loss_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      period_r    <= period_nxt;
      prev_r      <= prev_nxt;
      count_r     <= count_nxt;
      gain_r      <= gain_nxt;
      loss_r      <= loss_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r      <= last_nxt;
    res_r       <= res_nxt;
    res_short_r <= res_short_nxt;
    out_rsi_r   <= out_rsi_nxt;
    out_short_r <= out_short_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_rsi_value    = out_rsi_r;
  assign out_short_series = out_short_r;

endmodule

`default_nettype wire

@@ rtl/core/rsi_checker.sv @@
// port-level checker for relative_strength_index_top, attached by bind
// depends on rsi_pkg and relative_strength_index_top_macros.svh
`default_nettype none
`include "relative_strength_index_top_macros.svh"

module rsi_checker #(
  parameter int FRACTION_BITS = rsi_pkg::FRACTION_BITS_DEF
) (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    in_last,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [rsi_pkg::RSI_BITS-1:0] out_rsi_value,
  input wire logic                    out_short_series
);
  import rsi_pkg::*;

  localparam logic [RSI_BITS-1:0] FIFTY_FX = RSI_BITS'(ACC_BITS'(50) << FRACTION_BITS);

  // a stalled result beat holds
  `RSI_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_rsi_value) && $stable(out_short_series), "result beat changed while stalled")

  // short series always reports fifty
  `RSI_ASSERT_IMP(a_short_fifty, out_valid && out_short_series, out_rsi_value == FIFTY_FX, "short series result is not fifty")

  // closing a series always takes the input side busy
  `RSI_ASSERT_NXT(a_last_busy, in_valid && in_ready && in_last, !in_ready, "input still ready after a last beat")

  // a new result only appears after a busy cycle
  `RSI_ASSERT_IMP(a_result_after_busy, $rose(out_valid), $past(!in_ready), "result appeared without a busy cycle")

endmodule

bind relative_strength_index_top rsi_checker #(
  .FRACTION_BITS (FRACTION_BITS)
) u_rsi_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_last          (in_last),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_rsi_value    (out_rsi_value),
  .out_short_series (out_short_series)
);

`default_nettype wire
